[hdl/vac_pkg.sv]
// vac_pkg: register indexes, field widths and fixed arithmetic constants
// for the volume axis convolution block
// no dependencies
package vac_pkg;

    // configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [REG_IDX_W-1:0] REG_AXIS_SELECT    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TAP_RADIUS     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_TAPS_LOW_WORD  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TAPS_HIGH_WORD = 3'd6;

    // register field widths
    localparam int AXIS_W      = 2;
    localparam int SIZE_W      = 8;
    localparam int RADIUS_W    = 2;
    localparam int TAPS_LOW_W  = 64;
    localparam int TAPS_HIGH_W = 48;
    localparam int TAPS_ALL_W  = TAPS_LOW_W + TAPS_HIGH_W;

    // axis codes, code three acts as z
    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    // reset values
    localparam logic [SIZE_W-1:0]   SIZE_RESET   = 8'd64;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 2'd3;

    // largest radius the register can encode
    localparam int RADIUS_CAP = 3;

    // taps are signed q2.14
    localparam int TAP_W      = 16;
    localparam int TAP_FRAC   = 14;
    localparam int ROUND_BIAS = 1 << (TAP_FRAC - 1);

    // cycles for derived configuration to settle after a write or reset
    localparam int           SETTLE_W      = 2;
    localparam logic [1:0]   SETTLE_CYCLES = 2'd2;

endpackage

[hdl/vac_raster_counter.sv]
// vac_raster_counter: x fastest raster position counter over a 3d volume
// no package dependencies; the top level sets its widths
module vac_raster_counter #(
    parameter int POS_W = 7,
    parameter int EXT_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic             clear,
    input  logic [EXT_W-1:0] size_x,
    input  logic [EXT_W-1:0] size_y,
    input  logic [EXT_W-1:0] size_z,
    output logic [POS_W-1:0] pos_x,
    output logic [POS_W-1:0] pos_y,
    output logic [POS_W-1:0] pos_z,
    output logic             wrap
);

    logic [POS_W-1:0] pos_x_reg;
    logic [POS_W-1:0] pos_y_reg;
    logic [POS_W-1:0] pos_z_reg;
    logic             x_end;
    logic             y_end;
    logic             z_end;

    assign x_end = (int'(pos_x_reg) + 1) >= int'(size_x);
    assign y_end = (int'(pos_y_reg) + 1) >= int'(size_y);
    assign z_end = (int'(pos_z_reg) + 1) >= int'(size_z);
    assign wrap  = x_end && y_end && z_end;

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            pos_z_reg <= '0;
        end else if (step) begin
            if (!x_end) begin
                pos_x_reg <= pos_x_reg + POS_W'(1);
            end else begin
                pos_x_reg <= '0;
                if (!y_end) begin
                    pos_y_reg <= pos_y_reg + POS_W'(1);
                end else begin
                    pos_y_reg <= '0;
                    if (!z_end) begin
                        pos_z_reg <= pos_z_reg + POS_W'(1);
                    end else begin
                        pos_z_reg <= '0;
                    end
                end
            end
        end
    end

    assign pos_x = pos_x_reg;
    assign pos_y = pos_y_reg;
    assign pos_z = pos_z_reg;

endmodule

[hdl/vac_window_mem.sv]
// vac_window_mem: single port pair delay line memory with registered read,
// and write to read forwarding when one edge reads and writes one entry
// no package dependencies
module vac_window_mem #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 96,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;
    logic [WIDTH-1:0] fwd_data_reg;
    logic             fwd_hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // read and write of the same entry at one edge: take the new data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

[hdl/vac_mac_pipe.sv]
// vac_mac_pipe: per lane multiply, adder tree, round and saturate, output register
// depends on vac_pkg (tap format)
module vac_mac_pipe #(
    parameter int NTAP        = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [NTAP*SAMPLE_BITS-1:0]       in_window,
    input  logic [NTAP-1:0]                   in_mask,
    input  logic                              in_last,
    input  logic [NTAP*vac_pkg::TAP_W-1:0]    lane_taps,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [SAMPLE_BITS-1:0]            m_filtered,
    output logic                              m_last_voxel
);

    localparam int PROD_W = SAMPLE_BITS + vac_pkg::TAP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(NTAP) + 1;
    localparam int NPAIR  = (NTAP + 1) / 2;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed({{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO =
        $signed({{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}});

    logic signed [PROD_W-1:0] prod_reg [NTAP];
    logic                     prod_valid_reg;
    logic                     prod_last_reg;
    logic signed [SUM_W-1:0]  pair_reg [NPAIR];
    logic                     pair_valid_reg;
    logic                     pair_last_reg;
    logic signed [ACC_W-1:0]  total_reg;
    logic                     total_valid_reg;
    logic                     total_last_reg;
    logic [SAMPLE_BITS-1:0]   out_data_reg;
    logic                     out_valid_reg;
    logic                     out_last_reg;

    logic                     out_free;
    logic                     total_free;
    logic                     pair_free;
    logic                     prod_free;
    logic signed [ACC_W-1:0]  total_sum;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-1:0]  scaled;

    assign out_free   = !out_valid_reg || m_ready;
    assign total_free = !total_valid_reg || out_free;
    assign pair_free  = !pair_valid_reg || total_free;
    assign prod_free  = !prod_valid_reg || pair_free;
    assign in_ready   = prod_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg  <= 1'b0;
            pair_valid_reg  <= 1'b0;
            total_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (prod_free) begin
                prod_valid_reg <= in_valid;
            end
            if (pair_free) begin
                pair_valid_reg <= prod_valid_reg;
            end
            if (total_free) begin
                total_valid_reg <= pair_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= total_valid_reg;
            end
        end
    end

    // lane products, lanes outside the volume contribute zero
    always_ff @(posedge aclk) begin
        if (prod_free && in_valid) begin
            prod_last_reg <= in_last;
            for (int j = 0; j < NTAP; j++) begin
                if (in_mask[j]) begin
                    prod_reg[j] <= $signed(in_window[j*SAMPLE_BITS +: SAMPLE_BITS])
                                 * $signed(lane_taps[j*vac_pkg::TAP_W +: vac_pkg::TAP_W]);
                end else begin
                    prod_reg[j] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pair_free && prod_valid_reg) begin
            pair_last_reg <= prod_last_reg;
            for (int i = 0; i < NPAIR; i++) begin
                if (2 * i + 1 < NTAP) begin
                    pair_reg[i] <= SUM_W'(prod_reg[2*i]) + SUM_W'(prod_reg[2*i+1]);
                end else begin
                    pair_reg[i] <= SUM_W'(prod_reg[2*i]);
                end
            end
        end
    end

    always_comb begin
        total_sum = '0;
        for (int i = 0; i < NPAIR; i++) begin
            total_sum = total_sum + ACC_W'(pair_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (total_free && pair_valid_reg) begin
            total_reg      <= total_sum;
            total_last_reg <= pair_last_reg;
        end
    end

    // round half up, then clip to the sample range
    assign biased = total_reg + ACC_W'(vac_pkg::ROUND_BIAS);
    assign scaled = biased >>> vac_pkg::TAP_FRAC;

    always_ff @(posedge aclk) begin
        if (out_free && total_valid_reg) begin
            out_last_reg <= total_last_reg;
            if (scaled > SAT_HI) begin
                out_data_reg <= SAT_HI[SAMPLE_BITS-1:0];
            end else if (scaled < SAT_LO) begin
                out_data_reg <= SAT_LO[SAMPLE_BITS-1:0];
            end else begin
                out_data_reg <= scaled[SAMPLE_BITS-1:0];
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_filtered   = out_data_reg;
    assign m_last_voxel = out_last_reg;

endmodule

[hdl/volume_axis_convolution.sv]
// volume_axis_convolution: top level, configuration, raster control, window stage
// depends on vac_pkg, vac_raster_counter, vac_window_mem, vac_mac_pipe
//
// usage
//   input channel s_*: one voxel per transfer in raster order, x fastest.
//   after the last voxel, send R * stride transfers with s_drain high
//   (stride 1, size_x or size_x*size_y for axis x, y, z) to flush the tail.
//   a drain transfer before the volume is complete is taken and dropped.
//   result channel m_*: one filtered voxel per output transfer, in raster
//   order; m_last_voxel marks the final voxel, after which a new volume starts.
//   configuration port: cfg_we writes cfg_wdata to register cfg_index at once;
//   write only between volumes.
// timing
//   one transfer per cycle in both directions when m_ready stays high.
//   a voxel's result shows on m_valid once the transfer that completes its
//   window has passed the memory read, multiply, two adder levels and round.
//   the window sits in one delay line memory, MAX_EXTENT squared entries (stride
//   used), each of 2R earlier samples; one read and one write-back per transfer.
//   after reset and after each config write, s_ready is held low while
//   stride, delay and lane taps are recomputed.
// stall
//   when m_ready is low, the internal stages fill up first; s_ready drops
//   only once every stage holds a result. reset clears all control state;
//   the window memory is not cleared (out-of-volume lanes are masked).
module volume_axis_convolution #(
    parameter int MAX_EXTENT  = 128,
    parameter int MAX_RADIUS  = 3,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [vac_pkg::REG_IDX_W-1:0]    cfg_index,
    input  logic [vac_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [SAMPLE_BITS-1:0]           s_sample,
    input  logic                             s_drain,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [SAMPLE_BITS-1:0]           m_filtered,
    output logic                             m_last_voxel
);

    localparam int POS_W    = $clog2(MAX_EXTENT);
    localparam int EXT_W    = $clog2(MAX_EXTENT + 1);
    localparam int DEPTH    = MAX_EXTENT * MAX_EXTENT;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int STRIDE_W = $clog2(DEPTH + 1);
    localparam int R_LIM    = (MAX_RADIUS < vac_pkg::RADIUS_CAP) ? MAX_RADIUS
                                                                 : vac_pkg::RADIUS_CAP;
    localparam int NTAP     = 2 * R_LIM + 1;
    localparam int DELAY_W  = $clog2(R_LIM * DEPTH + 1);
    localparam int MEM_W    = 2 * R_LIM * SAMPLE_BITS;
    localparam int WIN_W    = NTAP * SAMPLE_BITS;
    localparam int TAP_W    = vac_pkg::TAP_W;

    // configuration registers
    logic [vac_pkg::AXIS_W-1:0]      axis_select_reg;
    logic [vac_pkg::SIZE_W-1:0]      size_x_reg;
    logic [vac_pkg::SIZE_W-1:0]      size_y_reg;
    logic [vac_pkg::SIZE_W-1:0]      size_z_reg;
    logic [vac_pkg::RADIUS_W-1:0]    tap_radius_reg;
    logic [vac_pkg::TAPS_LOW_W-1:0]  taps_low_reg;
    logic [vac_pkg::TAPS_HIGH_W-1:0] taps_high_reg;
    logic [vac_pkg::SETTLE_W-1:0]    settle_reg;

    // derived configuration
    logic [EXT_W-1:0]              sx_c_reg;
    logic [EXT_W-1:0]              sy_c_reg;
    logic [EXT_W-1:0]              sz_c_reg;
    logic [vac_pkg::RADIUS_W-1:0]  radius_reg;
    logic [vac_pkg::RADIUS_W-1:0]  radius_c;
    logic [STRIDE_W-1:0]           stride_reg;
    logic [DELAY_W-1:0]            delay_reg;
    logic [TAP_W-1:0]              lane_tap_reg [NTAP];
    logic [NTAP*TAP_W-1:0]         lane_taps;
    logic [vac_pkg::TAPS_ALL_W-1:0] taps_all;

    // stream control
    logic                in_done_reg;
    logic [DELAY_W-1:0]  fill_reg;
    logic [ADDR_W-1:0]   ptr_reg;
    logic                accept;
    logic                live;
    logic                produce;
    logic                in_step;
    logic                out_step;
    logic                last;
    logic                in_wrap;
    logic                out_wrap;
    logic [POS_W-1:0]    out_x;
    logic [POS_W-1:0]    out_y;
    logic [POS_W-1:0]    out_z;
    logic [POS_W-1:0]    base;
    logic [EXT_W-1:0]    lim;
    logic [NTAP-1:0]     lane_mask;

    // window stage, holds one transfer while its memory read returns
    logic                   a_valid_reg;
    logic                   a_out_reg;
    logic                   a_last_reg;
    logic [NTAP-1:0]        a_mask_reg;
    logic [ADDR_W-1:0]      a_addr_reg;
    logic [SAMPLE_BITS-1:0] a_sample_reg;
    logic                   a_leave;
    logic                   a_free;
    logic [MEM_W-1:0]       mem_rd_data;
    logic [WIN_W-1:0]       window;
    logic                   mac_ready;

    function automatic logic [EXT_W-1:0] clamp_size(input logic [vac_pkg::SIZE_W-1:0] sz);
        logic [EXT_W-1:0] res;
        if (sz == '0) begin
            res = EXT_W'(1);
        end else if (int'(sz) > MAX_EXTENT) begin
            res = EXT_W'(MAX_EXTENT);
        end else begin
            res = EXT_W'(sz);
        end
        return res;
    endfunction

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_select_reg <= vac_pkg::AXIS_X;
            size_x_reg      <= vac_pkg::SIZE_RESET;
            size_y_reg      <= vac_pkg::SIZE_RESET;
            size_z_reg      <= vac_pkg::SIZE_RESET;
            tap_radius_reg  <= vac_pkg::RADIUS_RESET;
            taps_low_reg    <= '0;
            taps_high_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                vac_pkg::REG_AXIS_SELECT: begin
                    axis_select_reg <= cfg_wdata[vac_pkg::AXIS_W-1:0];
                end
                vac_pkg::REG_SIZE_X: begin
                    size_x_reg <= cfg_wdata[vac_pkg::SIZE_W-1:0];
                end
                vac_pkg::REG_SIZE_Y: begin
                    size_y_reg <= cfg_wdata[vac_pkg::SIZE_W-1:0];
                end
                vac_pkg::REG_SIZE_Z: begin
                    size_z_reg <= cfg_wdata[vac_pkg::SIZE_W-1:0];
                end
                vac_pkg::REG_TAP_RADIUS: begin
                    tap_radius_reg <= cfg_wdata[vac_pkg::RADIUS_W-1:0];
                end
                vac_pkg::REG_TAPS_LOW_WORD: begin
                    taps_low_reg <= cfg_wdata[vac_pkg::TAPS_LOW_W-1:0];
                end
                vac_pkg::REG_TAPS_HIGH_WORD: begin
                    taps_high_reg <= cfg_wdata[vac_pkg::TAPS_HIGH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // hold off input while derived values catch up
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we) begin
            settle_reg <= vac_pkg::SETTLE_CYCLES;
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - vac_pkg::SETTLE_W'(1);
        end
    end

    assign radius_c = (int'(tap_radius_reg) > R_LIM) ? vac_pkg::RADIUS_W'(R_LIM)
                                                     : tap_radius_reg;
    assign taps_all = {taps_high_reg, taps_low_reg};

    // first settle cycle: clamped sizes, stride, lane taps
    // lane j carries the sample j strides back, so it uses tap 2R-j
    always_ff @(posedge aclk) begin
        sx_c_reg   <= clamp_size(size_x_reg);
        sy_c_reg   <= clamp_size(size_y_reg);
        sz_c_reg   <= clamp_size(size_z_reg);
        radius_reg <= radius_c;
        unique case (axis_select_reg)
            vac_pkg::AXIS_X: begin
                stride_reg <= STRIDE_W'(1);
            end
            vac_pkg::AXIS_Y: begin
                stride_reg <= STRIDE_W'(clamp_size(size_x_reg));
            end
            default: begin
                stride_reg <= STRIDE_W'(clamp_size(size_x_reg))
                            * STRIDE_W'(clamp_size(size_y_reg));
            end
        endcase
        for (int j = 0; j < NTAP; j++) begin
            if (j <= 2 * int'(radius_c)) begin
                lane_tap_reg[j] <= taps_all[(2*int'(radius_c)-j)*TAP_W +: TAP_W];
            end else begin
                lane_tap_reg[j] <= '0;
            end
        end
    end

    // second settle cycle: transfers before the first result
    always_ff @(posedge aclk) begin
        delay_reg <= DELAY_W'(stride_reg) * DELAY_W'(radius_reg);
    end

    always_comb begin
        for (int j = 0; j < NTAP; j++) begin
            lane_taps[j*TAP_W +: TAP_W] = lane_tap_reg[j];
        end
    end

    // input transfer classification
    assign accept   = s_valid && s_ready;
    assign live     = accept && !(s_drain && !in_done_reg);
    assign produce  = fill_reg >= delay_reg;
    assign in_step  = live && !in_done_reg;
    assign out_step = live && produce;
    assign last     = out_step && out_wrap;

    vac_raster_counter #(
        .POS_W (POS_W),
        .EXT_W (EXT_W)
    ) u_in_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (in_step),
        .clear   (last),
        .size_x  (sx_c_reg),
        .size_y  (sy_c_reg),
        .size_z  (sz_c_reg),
        .pos_x   (),
        .pos_y   (),
        .pos_z   (),
        .wrap    (in_wrap)
    );

    vac_raster_counter #(
        .POS_W (POS_W),
        .EXT_W (EXT_W)
    ) u_out_pos (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (out_step),
        .clear   (last),
        .size_x  (sx_c_reg),
        .size_y  (sy_c_reg),
        .size_z  (sz_c_reg),
        .pos_x   (out_x),
        .pos_y   (out_y),
        .pos_z   (out_z),
        .wrap    (out_wrap)
    );

    // coordinate along the filter axis and its extent
    always_comb begin
        unique case (axis_select_reg)
            vac_pkg::AXIS_X: begin
                base = out_x;
                lim  = sx_c_reg;
            end
            vac_pkg::AXIS_Y: begin
                base = out_y;
                lim  = sy_c_reg;
            end
            default: begin
                base = out_z;
                lim  = sz_c_reg;
            end
        endcase
    end

    // zero padding: lane j looks at axis coordinate base + R - j
    always_comb begin
        for (int j = 0; j < NTAP; j++) begin
            lane_mask[j] = (j <= 2 * int'(radius_reg))
                        && (int'(base) + int'(radius_reg) - j >= 0)
                        && (int'(base) + int'(radius_reg) - j < int'(lim));
        end
    end

    // stream state
    always_ff @(posedge aclk) begin
        if (!aresetn || last) begin
            in_done_reg <= 1'b0;
            fill_reg    <= '0;
            ptr_reg     <= '0;
        end else if (live) begin
            if (in_step && in_wrap) begin
                in_done_reg <= 1'b1;
            end
            if (!produce) begin
                fill_reg <= fill_reg + DELAY_W'(1);
            end
            if (STRIDE_W'(ptr_reg) + STRIDE_W'(1) >= stride_reg) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= ptr_reg + ADDR_W'(1);
            end
        end
    end

    // window stage
    assign a_leave = a_valid_reg && (!a_out_reg || mac_ready);
    assign a_free  = !a_valid_reg || a_leave;
    assign s_ready = a_free && (settle_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_free) begin
            a_valid_reg <= live;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_free && live) begin
            a_out_reg    <= produce;
            a_last_reg   <= out_wrap;
            a_mask_reg   <= lane_mask;
            a_addr_reg   <= ptr_reg;
            a_sample_reg <= in_done_reg ? '0 : s_sample;
        end
    end

    // newest sample in lane 0, older ones from the delay line entry
    assign window = {mem_rd_data, a_sample_reg};

    vac_window_mem #(
        .DEPTH (DEPTH),
        .WIDTH (MEM_W)
    ) u_window_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (live),
        .rd_addr (ptr_reg),
        .wr_en   (a_leave),
        .wr_addr (a_addr_reg),
        .wr_data (window[MEM_W-1:0]),
        .rd_data (mem_rd_data)
    );

    vac_mac_pipe #(
        .NTAP        (NTAP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (a_valid_reg && a_out_reg),
        .in_ready     (mac_ready),
        .in_window    (window),
        .in_mask      (a_mask_reg),
        .in_last      (a_last_reg),
        .lane_taps    (lane_taps),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_filtered   (m_filtered),
        .m_last_voxel (m_last_voxel)
    );

endmodule
